// ===== src/mnvrw_pkg.sv =====
// ---------------------------------------------------------------------------
// MIDI note to voice register writes: shared package
// Widths, register offsets, register values, the semitone table and the
// command type that passes from the byte decoder to the voice engine.
// ---------------------------------------------------------------------------
package mnvrw_pkg;

  localparam int MIDI_W  = 8;
  localparam int ADDR_W  = 5;
  localparam int VALUE_W = 8;
  localparam int FREQ_W  = 16;

  localparam int MAX_VOICES       = 3;
  localparam int DEF_VOICES       = 3;
  localparam int DEF_CHIP_CLOCK   = 985248;
  localparam int NUM_NOTES        = 128;
  localparam int NOTE_IDX_W       = 7;
  localparam int VOICE_STRIDE     = 7;
  localparam int FIFO_DEPTH       = 2;

  localparam logic [3:0] STATUS_NOTE_ON  = 4'h9;
  localparam logic [3:0] STATUS_NOTE_OFF = 4'h8;
  localparam logic [7:0] NO_STATUS       = 8'h00;
  localparam logic [7:0] FREE_NOTE       = 8'hff;

  localparam logic [ADDR_W-1:0] OFF_FREQ_LO = 5'd0;
  localparam logic [ADDR_W-1:0] OFF_FREQ_HI = 5'd1;
  localparam logic [ADDR_W-1:0] OFF_CTRL    = 5'd4;
  localparam logic [ADDR_W-1:0] OFF_AD      = 5'd5;
  localparam logic [ADDR_W-1:0] OFF_SR      = 5'd6;

  localparam logic [VALUE_W-1:0] VAL_AD       = 8'h09;
  localparam logic [VALUE_W-1:0] VAL_SR       = 8'hf3;
  localparam logic [VALUE_W-1:0] VAL_GATE_ON  = 8'h21;
  localparam logic [VALUE_W-1:0] VAL_GATE_OFF = 8'h20;

  localparam logic [31:0] SEMITONE_Q24 [12] = '{
    32'd16777216, 32'd17774841, 32'd18831788, 32'd19951585,
    32'd21137968, 32'd22394897, 32'd23726566, 32'd25137421,
    32'd26632170, 32'd28215802, 32'd29893600, 32'd31671166
  };

  typedef struct packed {
    logic              note_on;
    logic [MIDI_W-1:0] note;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_st_t;

endpackage

// ===== src/mnvrw_if.sv =====
// ---------------------------------------------------------------------------
// MIDI note to voice register writes: channel interfaces
// Valid/ready channels for incoming MIDI bytes and outgoing register writes.
// ---------------------------------------------------------------------------
interface mnvrw_midi_if;
  import mnvrw_pkg::*;

  logic              valid;
  logic              ready;
  logic [MIDI_W-1:0] midi_byte;

  modport source (output valid, output midi_byte, input ready);
  modport sink (input valid, input midi_byte, output ready);
endinterface

interface mnvrw_wr_if;
  import mnvrw_pkg::*;

  logic               valid;
  logic               ready;
  logic [ADDR_W-1:0]  reg_addr;
  logic [VALUE_W-1:0] reg_value;
  logic               last;

  modport source (output valid, output reg_addr, output reg_value, output last, input ready);
  modport sink (input valid, input reg_addr, input reg_value, input last, output ready);
endinterface

// ===== src/mnvrw_front.sv =====
// ---------------------------------------------------------------------------
// MIDI note to voice register writes: byte decoder
// Tracks running status, pairs data bytes and turns note messages into
// note-on and note-off commands for the command queue.
// ---------------------------------------------------------------------------
module mnvrw_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  mnvrw_midi_if.sink      midi_i,
  input  logic            full_i,
  output logic            push_o,
  output mnvrw_pkg::cmd_t cmd_o
);
  import mnvrw_pkg::*;

  logic [MIDI_W-1:0] status_q;
  logic              count_q;
  logic [MIDI_W-1:0] first_q;
  logic              take;
  logic              pair_done;

  assign midi_i.ready = !full_i;
  assign take         = midi_i.valid && !full_i;
  assign pair_done    = take && !midi_i.midi_byte[7] && (status_q != NO_STATUS) && count_q;

  always_comb begin
    push_o        = 1'b0;
    cmd_o.note    = first_q;
    cmd_o.note_on = (status_q[7:4] == STATUS_NOTE_ON) && (midi_i.midi_byte != '0);
    if (pair_done && ((status_q[7:4] == STATUS_NOTE_ON) ||
                      (status_q[7:4] == STATUS_NOTE_OFF))) begin
      push_o = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= NO_STATUS;
      count_q  <= 1'b0;
      first_q  <= '0;
    end else if (take) begin
      if (midi_i.midi_byte[7]) begin
        status_q <= midi_i.midi_byte;
        count_q  <= 1'b0;
      end else if (status_q != NO_STATUS) begin
        if (!count_q) begin
          first_q <= midi_i.midi_byte;
          count_q <= 1'b1;
        end else begin
          count_q <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== src/mnvrw_cmd_fifo.sv =====
// ---------------------------------------------------------------------------
// MIDI note to voice register writes: command queue
// Short first-in first-out queue between the byte decoder and voice engine.
// ---------------------------------------------------------------------------
module mnvrw_cmd_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  mnvrw_pkg::cmd_t     cmd_i,
  input  logic                pop_i,
  output mnvrw_pkg::cmd_t     cmd_o,
  output mnvrw_pkg::fifo_st_t st_o
);
  import mnvrw_pkg::*;

  localparam int PtrW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CntW = $clog2(FIFO_DEPTH + 1);

  cmd_t            mem_q [FIFO_DEPTH];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push;
  logic            do_pop;

  assign st_o.empty = (count_q == '0);
  assign st_o.full  = (count_q == CntW'(FIFO_DEPTH));
  assign do_push    = push_i && !st_o.full;
  assign do_pop     = pop_i && !st_o.empty;
  assign cmd_o      = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== src/mnvrw_back.sv =====
// ---------------------------------------------------------------------------
// MIDI note to voice register writes: voice engine
// Allocates voices round robin, looks up note frequencies and issues the
// register write sequence for each command, one write per unstalled cycle.
// ---------------------------------------------------------------------------
module mnvrw_back #(
  parameter int unsigned VOICES        = mnvrw_pkg::DEF_VOICES,
  parameter int unsigned CHIP_CLOCK_HZ = mnvrw_pkg::DEF_CHIP_CLOCK
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mnvrw_pkg::cmd_t     cmd_i,
  input  mnvrw_pkg::fifo_st_t fifo_st_i,
  output logic                pop_o,
  output logic                busy_o,
  mnvrw_wr_if.source          wr_o
);
  import mnvrw_pkg::*;

  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;

  typedef enum logic [2:0] {
    STEP_FREQ_LO,
    STEP_FREQ_HI,
    STEP_AD,
    STEP_SR,
    STEP_CTRL
  } step_e;

  logic [FREQ_W-1:0]  freq_rom [NUM_NOTES];

  for (genvar gn = 0; gn < NUM_NOTES; gn++) begin : g_rom
    localparam int Shift = gn + 3;
    localparam int Oct   = Shift / 12 - 6;
    localparam int Semi  = Shift % 12;
    localparam longint unsigned Num =
      (64'(440) * 64'(SEMITONE_Q24[Semi])) << ((Oct > 0) ? Oct : 0);
    localparam longint unsigned Den = 64'(CHIP_CLOCK_HZ) << ((Oct < 0) ? -Oct : 0);
    localparam longint unsigned Quo = (Den == 0) ? 64'(65535) : (Num * 2 + Den) / (Den * 2);
    assign freq_rom[gn] = (Quo > 64'(65535)) ? 16'hffff : 16'(Quo);
  end

  logic               busy_q;
  logic               on_q;
  step_e              step_q;
  logic [VW-1:0]      voice_q;
  logic [VW-1:0]      next_q;
  logic [FREQ_W-1:0]  freq_q;
  logic [VOICES-1:0]  match_q;
  logic [MIDI_W-1:0]  held_q [VOICES];
  logic               out_valid_q;
  logic [ADDR_W-1:0]  out_addr_q;
  logic [VALUE_W-1:0] out_value_q;
  logic               out_last_q;

  logic               slot_free;
  logic               issue;
  logic               load;
  logic [VW-1:0]      sel;
  logic [VOICES-1:0]  remain;
  logic [VOICES-1:0]  hit;
  logic [ADDR_W-1:0]  em_off;
  logic [VW-1:0]      em_voice;
  logic [ADDR_W-1:0]  em_addr;
  logic [VALUE_W-1:0] em_value;
  logic               em_last;

  assign slot_free = !out_valid_q || wr_o.ready;
  assign issue     = busy_q && slot_free;
  assign load      = (!busy_q || (issue && em_last)) && !fifo_st_i.empty;
  assign pop_o     = load;
  assign busy_o    = busy_q;

  always_comb begin
    sel    = '0;
    remain = match_q;
    for (int v = VOICES - 1; v >= 0; v--) begin
      if (match_q[v]) begin
        sel = VW'(v);
      end
    end
    remain[sel] = 1'b0;
    for (int v = 0; v < VOICES; v++) begin
      hit[v] = (held_q[v] == cmd_i.note);
    end
  end

  always_comb begin
    em_off   = OFF_CTRL;
    em_value = VAL_GATE_OFF;
    em_voice = sel;
    em_last  = (remain == '0);
    if (on_q) begin
      em_voice = voice_q;
      em_last  = (step_q == STEP_CTRL);
      case (step_q)
        STEP_FREQ_LO: begin
          em_off   = OFF_FREQ_LO;
          em_value = freq_q[7:0];
        end
        STEP_FREQ_HI: begin
          em_off   = OFF_FREQ_HI;
          em_value = freq_q[15:8];
        end
        STEP_AD: begin
          em_off   = OFF_AD;
          em_value = VAL_AD;
        end
        STEP_SR: begin
          em_off   = OFF_SR;
          em_value = VAL_SR;
        end
        default: begin
          em_off   = OFF_CTRL;
          em_value = VAL_GATE_ON;
        end
      endcase
    end
    em_addr = ADDR_W'(ADDR_W'(em_voice) * ADDR_W'(VOICE_STRIDE)) + em_off;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      on_q        <= 1'b0;
      step_q      <= STEP_FREQ_LO;
      voice_q     <= '0;
      next_q      <= '0;
      freq_q      <= '0;
      match_q     <= '0;
      out_valid_q <= 1'b0;
      out_addr_q  <= '0;
      out_value_q <= '0;
      out_last_q  <= 1'b0;
      for (int v = 0; v < VOICES; v++) begin
        held_q[v] <= FREE_NOTE;
      end
    end else begin
      if (slot_free) begin
        out_valid_q <= issue;
        if (issue) begin
          out_addr_q  <= em_addr;
          out_value_q <= em_value;
          out_last_q  <= em_last;
        end
      end
      if (issue) begin
        if (on_q) begin
          step_q <= step_e'(step_q + 3'd1);
        end else begin
          match_q <= remain;
        end
        if (em_last) begin
          busy_q <= 1'b0;
        end
      end
      if (load) begin
        on_q   <= cmd_i.note_on;
        step_q <= STEP_FREQ_LO;
        if (cmd_i.note_on) begin
          busy_q         <= 1'b1;
          voice_q        <= next_q;
          held_q[next_q] <= cmd_i.note;
          next_q         <= (next_q == VW'(VOICES - 1)) ? '0 : next_q + 1'b1;
          freq_q         <= freq_rom[cmd_i.note[NOTE_IDX_W-1:0]];
        end else begin
          busy_q  <= |hit;
          match_q <= hit;
          for (int v = 0; v < VOICES; v++) begin
            if (hit[v]) begin
              held_q[v] <= FREE_NOTE;
            end
          end
        end
      end
    end
  end

  assign wr_o.valid     = out_valid_q;
  assign wr_o.reg_addr  = out_addr_q;
  assign wr_o.reg_value = out_value_q;
  assign wr_o.last      = out_last_q;

endmodule

// ===== src/midi_note_to_voice_register_writes_top.sv =====
// ---------------------------------------------------------------------------
// MIDI note to voice register writes: top level
// Turns a raw MIDI byte stream into sound chip voice register writes.
// ---------------------------------------------------------------------------
// MIDI bytes enter on midi_i, one byte per accepted word, and register writes
// leave on wr_o, each word carrying an address, a value and a last flag that
// marks the final write caused by one byte. A decoder tracks running status
// and pairs data bytes; completed note messages go into a two-entry command
// queue; the voice engine drains it and issues one write per cycle unless
// wr_o stalls. A note-on produces five writes; a note-off produces one
// write per voice holding the note, or none. The writes of successive
// queued commands follow each other with no gap; a note-off that frees no
// voice leaves an idle gap. Bytes are accepted every cycle while the
// command queue has room, so a sustained stream of note-ons is paced by
// the five writes of each note. When the receiver stalls, the output
// register holds its write, the engine waits, the queue fills and then
// midi_i.ready drops. Reset clears running status, frees every voice and
// restarts allocation at voice zero; the frequency table is built at
// elaboration.
// ---------------------------------------------------------------------------
module midi_note_to_voice_register_writes_top #(
  parameter int unsigned VOICES        = mnvrw_pkg::DEF_VOICES,
  parameter int unsigned CHIP_CLOCK_HZ = mnvrw_pkg::DEF_CHIP_CLOCK
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mnvrw_midi_if.sink midi_i,
  mnvrw_wr_if.source wr_o
);
  import mnvrw_pkg::*;

  logic     push;
  logic     pop;
  logic     busy;
  cmd_t     cmd_in;
  cmd_t     cmd_out;
  fifo_st_t fifo_st;

  mnvrw_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .midi_i (midi_i),
    .full_i (fifo_st.full),
    .push_o (push),
    .cmd_o  (cmd_in)
  );

  mnvrw_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd_in),
    .pop_i  (pop),
    .cmd_o  (cmd_out),
    .st_o   (fifo_st)
  );

  mnvrw_back #(
    .VOICES        (VOICES),
    .CHIP_CLOCK_HZ (CHIP_CLOCK_HZ)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd_out),
    .fifo_st_i (fifo_st),
    .pop_o     (pop),
    .busy_o    (busy),
    .wr_o      (wr_o)
  );

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !fifo_st.full)
    else $error("Command pushed into a full queue.");

  a_partial_keeps_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_o.valid && !wr_o.last) |-> busy)
    else $error("Voice engine idle while a write sequence is unfinished.");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !fifo_st.empty)
    else $error("Command popped from an empty queue.");

endmodule

// ===== dv/testbench.sv =====
// ---------------------------------------------------------------------------
// MIDI note to voice register writes: testbench
// Sends raw MIDI bytes into the block and checks every register write that it
// issues against an in-bench model of running status, round-robin voice
// allocation and the note frequency table. The run starts with a directed
// byte sequence and continues with random note traffic, with random idle
// cycles on the byte side and random stalls on the write side.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mnvrw_pkg::*;

  localparam int unsigned NUM_VOICES = DEF_VOICES;
  localparam int unsigned CHIP_CLOCK = DEF_CHIP_CLOCK;
  localparam int          STIM_BYTES = 310;

  typedef struct {
    logic [ADDR_W-1:0]  addr;
    logic [VALUE_W-1:0] value;
    logic               last;
  } reg_write_t;

  typedef struct {
    bit                hold_for_drain;
    logic [MIDI_W-1:0] midi;
  } midi_stim_t;

  logic clk_i;
  logic rst_ni;

  mnvrw_midi_if midi ();
  mnvrw_wr_if   wr ();

  midi_note_to_voice_register_writes_top #(
    .VOICES        (NUM_VOICES),
    .CHIP_CLOCK_HZ (CHIP_CLOCK)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .midi_i (midi),
    .wr_o   (wr)
  );

  midi_stim_t stim_queue[$];
  reg_write_t expected_writes[$];

  logic [7:0] run_status = NO_STATUS;
  bit         have_first = 1'b0;
  logic [7:0] first_data = 8'h00;
  logic [7:0] held_note[MAX_VOICES] = '{default: FREE_NOTE};
  int         rr_voice = 0;

  int mismatches = 0;
  int stim_bytes = 0;
  int bytes_sent = 0;
  int writes_checked = 0;
  int notes_started = 0;
  int gates_closed = 0;
  int saturated = 0;

  int send_gap = 0;
  int recv_stall = 0;
  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [FREQ_W-1:0] voice_freq(logic [7:0] note);
    int semi;
    int oct;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] q;
    semi = int'(note[6:0]) - 69;
    oct = 0;
    while (semi < 0) begin
      semi += 12;
      oct--;
    end
    while (semi >= 12) begin
      semi -= 12;
      oct++;
    end
    num = 64'd440 * 64'(SEMITONE_Q24[semi]);
    den = 64'(CHIP_CLOCK);
    if (oct >= 0) begin
      num = num << oct;
    end else begin
      den = den << (-oct);
    end
    q = (2 * num + den) / (2 * den);
    return (q > 64'd65535) ? 16'hffff : q[FREQ_W-1:0];
  endfunction

  task automatic push_write(logic [ADDR_W-1:0] addr, logic [VALUE_W-1:0] value, logic last);
    reg_write_t w;
    w.addr = addr;
    w.value = value;
    w.last = last;
    expected_writes.push_back(w);
  endtask

  task automatic predict_midi_byte(logic [7:0] data);
    logic [7:0] note;
    logic [FREQ_W-1:0] freq;
    logic [ADDR_W-1:0] base;
    int v;
    int hits;
    if (data[7]) begin
      run_status = data;
      have_first = 1'b0;
      return;
    end
    if (run_status == NO_STATUS) return;
    if (!have_first) begin
      first_data = data;
      have_first = 1'b1;
      return;
    end
    have_first = 1'b0;
    note = first_data;
    if (run_status[7:4] == STATUS_NOTE_ON && data != 8'h00) begin
      v = rr_voice;
      rr_voice = (v + 1 >= NUM_VOICES) ? 0 : v + 1;
      held_note[v] = note;
      freq = voice_freq(note);
      if (freq == 16'hffff) saturated++;
      notes_started++;
      base = ADDR_W'(VOICE_STRIDE * v);
      push_write(base + OFF_FREQ_LO, freq[7:0], 1'b0);
      push_write(base + OFF_FREQ_HI, freq[15:8], 1'b0);
      push_write(base + OFF_AD, VAL_AD, 1'b0);
      push_write(base + OFF_SR, VAL_SR, 1'b0);
      push_write(base + OFF_CTRL, VAL_GATE_ON, 1'b1);
    end else if (run_status[7:4] == STATUS_NOTE_ON || run_status[7:4] == STATUS_NOTE_OFF) begin
      hits = 0;
      for (v = 0; v < NUM_VOICES; v++) begin
        if (held_note[v] == note) begin
          held_note[v] = FREE_NOTE;
          push_write(ADDR_W'(VOICE_STRIDE * v) + OFF_CTRL, VAL_GATE_OFF, 1'b0);
          hits++;
        end
      end
      if (hits > 0) expected_writes[expected_writes.size() - 1].last = 1'b1;
      gates_closed += hits;
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH at %0t: %s got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic add_byte(logic [7:0] data);
    midi_stim_t s;
    s.hold_for_drain = 1'b0;
    s.midi = data;
    stim_queue.push_back(s);
    stim_bytes++;
  endtask

  task automatic add_drain();
    midi_stim_t s;
    s.hold_for_drain = 1'b1;
    s.midi = 8'h00;
    stim_queue.push_back(s);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      midi.valid <= 1'b0;
      midi.midi_byte <= '0;
      send_gap = 0;
    end else begin
      if (midi.valid && midi.ready) begin
        predict_midi_byte(midi.midi_byte);
        bytes_sent++;
      end
      if (!midi.valid || midi.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          midi.valid <= 1'b0;
        end else if (stim_queue.size() == 0) begin
          midi.valid <= 1'b0;
        end else if (stim_queue[0].hold_for_drain) begin
          if (expected_writes.size() == 0) void'(stim_queue.pop_front());
          midi.valid <= 1'b0;
        end else begin
          midi.midi_byte <= stim_queue.pop_front().midi;
          midi.valid <= 1'b1;
          if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
          send_gap = pick_gap(send_calm);
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    reg_write_t w;
    if (!rst_ni) begin
      wr.ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (wr.valid && wr.ready) begin
        writes_checked++;
        if (expected_writes.size() == 0) begin
          report_mismatch("unexpected write, addr", wr.reg_addr, 0);
        end else begin
          w = expected_writes.pop_front();
          if (wr.reg_addr !== w.addr) report_mismatch("reg_addr", wr.reg_addr, w.addr);
          if (wr.reg_value !== w.value) report_mismatch("reg_value", wr.reg_value, w.value);
          if (wr.last !== w.last) report_mismatch("last", wr.last, w.last);
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        wr.ready <= 1'b0;
      end else begin
        wr.ready <= 1'b1;
        if ($urandom_range(0, 63) == 0) recv_calm = !recv_calm;
        recv_stall = pick_gap(recv_calm);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Timeout waiting for register writes");
    $display("Verification failed");
    $finish;
  end

  initial begin : main
    logic [7:0] status;
    logic [6:0] note;
    logic [6:0] vel;
    int sel;
    int pairs;
    int r;

    rst_ni = 1'b0;

    // Data before any status, then note-ons at both ends of the note range,
    // a wrap of the voice allocation and a note held by two voices.
    add_byte(8'h3c);
    add_byte(8'h90);
    add_byte(8'h00); add_byte(8'h7f);
    add_byte(8'h7f); add_byte(8'h01);
    add_byte(8'h45); add_byte(8'h40);
    add_byte(8'h40); add_byte(8'h7f);
    add_byte(8'h40); add_byte(8'h7f);
    add_byte(8'h40); add_byte(8'h00);
    add_byte(8'h80); add_byte(8'h45); add_byte(8'h7f);
    add_byte(8'h05); add_byte(8'h00);
    add_byte(8'hb3); add_byte(8'h07); add_byte(8'h7f);
    // A real-time byte in the middle of a pair replaces the running status.
    add_byte(8'h9f); add_byte(8'h30); add_byte(8'hf8); add_byte(8'h40); add_byte(8'h55);
    add_byte(8'hff);
    add_drain();

    while (stim_bytes < STIM_BYTES) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        add_byte(8'($urandom_range(0, 255)));
      end else if (r < 10) begin
        add_drain();
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 55) begin
          status = {STATUS_NOTE_ON, 4'($urandom_range(0, 15))};
        end else if (sel < 85) begin
          status = {STATUS_NOTE_OFF, 4'($urandom_range(0, 15))};
        end else begin
          status = 8'($urandom_range(8'ha0, 8'hff));
        end
        add_byte(status);
        pairs = $urandom_range(1, 4);
        for (int i = 0; i < pairs; i++) begin
          if ($urandom_range(0, 3) == 0) begin
            note = 7'($urandom_range(0, 127));
          end else begin
            note = 7'($urandom_range(58, 65));
          end
          sel = $urandom_range(0, 9);
          if (sel == 0) begin
            vel = 7'd0;
          end else if (sel == 1) begin
            vel = 7'd127;
          end else begin
            vel = 7'($urandom_range(1, 126));
          end
          add_byte({1'b0, note});
          if ($urandom_range(0, 19) == 0) break;
          add_byte({1'b0, vel});
        end
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (stim_queue.size() != 0 || midi.valid) @(posedge clk_i);
    while (expected_writes.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d MIDI bytes: %0d note-ons, %0d gate-offs, %0d saturated frequencies.",
             bytes_sent, notes_started, gates_closed, saturated);
    $display("Checked %0d register writes with %0d mismatches.", writes_checked, mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/mnvrw_pkg.sv
src/mnvrw_if.sv
src/mnvrw_front.sv
src/mnvrw_cmd_fifo.sv
src/mnvrw_back.sv
src/midi_note_to_voice_register_writes_top.sv
dv/testbench.sv
